>>> rtl/shtqp_pkg.sv
// Package for the quadratic-probe string hash table.
// Status codes, default sizes and field widths. No dependencies.
package shtqp_pkg;

  localparam int SLOTS_DEF      = 101;
  localparam int MAX_PROBES_DEF = 20;
  localparam int KEY_CHARS_DEF  = 16;

  localparam int CMD_W    = 1;
  localparam int CHAR_W   = 7;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;
  localparam int COUNT_W  = 7;

  localparam int HASH_MUL  = 19;
  localparam int PROBE_LIN = 23;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DEL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_MISSING  = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

endpackage

>>> rtl/shtqp_if.sv
// Valid/ready channel interfaces for key characters and results.
// Depends on shtqp_pkg.
interface shtqp_in_if import shtqp_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] key_char;
  logic              last_char;
  modport source (output valid, cmd, key_char, last_char, input ready);
  modport sink   (input valid, cmd, key_char, last_char, output ready);
endinterface

interface shtqp_out_if import shtqp_pkg::*; (input logic clk);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  entry_count;
  modport source (output valid, status, slot, entry_count, input ready);
  modport sink   (input valid, status, slot, entry_count, output ready);
endinterface

>>> rtl/string_hash_table_quadratic_probe_top.sv
// Top level of the quadratic-probe string hash table.
// Depends on shtqp_pkg and the channel interfaces in shtqp_if.sv.
//
// Keys arrive one character per beat; the beat with last_char set carries
// add/delete. A final beat of a key longer than KEY_CHARS is answered at once
// with ST_TOO_LONG; otherwise the hash is computed in steps (product,
// reciprocal quotient, remainder), then up to MAX_PROBES slots are probed; each
// probe is a read of the key memory and valid bits followed by a compare. A
// probe chain stops at the first matching slot, otherwise every probe is read.
// No further beat is taken until the result beat has gone. After reset a
// clearing pass resets the valid memory; no beat is accepted meanwhile.
// Key words are kept one 128-bit entry per slot.
module string_hash_table_quadratic_probe_top
  import shtqp_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_PROBES = MAX_PROBES_DEF,
  parameter int KEY_CHARS  = KEY_CHARS_DEF
) (
  input logic        clk,
  input logic        rst,
  shtqp_in_if.sink   in_ch,
  shtqp_out_if.source out_ch
);

  localparam int SW   = $clog2(SLOTS);
  localparam int PW   = $clog2(KEY_CHARS + 2);
  localparam int JW   = $clog2(MAX_PROBES + 1);
  localparam int KW   = 128;
  localparam int HW   = 15 + 5;
  localparam int CW   = $clog2(SLOTS + 1);

  // hash reduction by reciprocal multiplication, exact for values below 2**NB
  localparam int CHAR_MAX = (1 << CHAR_W) - 1;
  localparam int HMAX     = CHAR_MAX * (KEY_CHARS * (KEY_CHARS + 1) / 2) * HASH_MUL;
  localparam int NB       = $clog2(HMAX + 1);
  localparam int MW       = NB + 1;
  localparam int RS       = NB + $clog2(SLOTS);
  localparam longint RECIP = ((longint'(1) << RS) + longint'(SLOTS - 1)) / longint'(SLOTS);

  typedef enum logic [3:0] {
    S_CLEAR, S_COLLECT, S_HASH, S_QUOT, S_MOD, S_READ, S_CMP, S_WRITE, S_OUT
  } state_t;
  state_t state;

  // slot memories: key words and valid bit, registered reads
  logic [KW-1:0] key_mem [SLOTS];
  logic          val_mem [SLOTS];
  logic [KW-1:0] rd_key;
  logic          rd_val;

  logic [KW-1:0] key_buf;
  logic [PW-1:0] pos;
  logic [HW-1:0] hsum;
  logic [SW-1:0] hash, probe, clr_idx;
  logic [JW-1:0] j;
  logic [SW:0]   step;        // 2j+24 mod SLOTS increment
  logic          cmd_r, found, have_free;
  logic [SW-1:0] hit_slot, free_slot;
  logic [CW-1:0] count;
  logic          wr_en, wr_val;
  logic [SW-1:0] wr_addr;

  logic [HW+5-1:0] hprod;
  logic [SW:0]     probe_sum, step_sum;
  logic [NB-1:0]   hval, quot, hrem;
  logic [NB+MW-1:0] qprod;

  assign hprod = (HW+5)'(hsum) * (HW+5)'(HASH_MUL);
  assign qprod = (NB+MW)'(hval) * (NB+MW)'(RECIP);
  assign hrem  = hval - quot * NB'(SLOTS);
  // probe j+1 = probe j + (2j+1+23); step held below SLOTS
  assign probe_sum = {1'b0, probe} + step;
  assign step_sum  = step + (SW+1)'(2 % SLOTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= key_buf;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[probe];
    rd_val <= val_mem[probe];
  end

  assign in_ch.ready = (state == S_COLLECT) && !out_ch.valid;

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_val  = 1'b0;
    wr_addr = clr_idx;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_WRITE) begin
      if (cmd_r == CMD_ADD && !found && have_free) begin
        wr_en = 1'b1; wr_val = 1'b1; wr_addr = free_slot;
      end else if (cmd_r == CMD_DEL && found) begin
        wr_en = 1'b1; wr_addr = hit_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      count        <= '0;
      key_buf      <= '0;
      pos          <= '0;
      hsum         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_idx == SW'(SLOTS - 1)) state <= S_COLLECT;
          clr_idx <= clr_idx + SW'(1);
        end
        S_COLLECT: begin
          if (acc) begin
            if (in_ch.last_char && pos >= PW'(KEY_CHARS)) begin
              // over-long key: answer at once, table untouched
              out_ch.status      <= ST_TOO_LONG;
              out_ch.slot        <= '0;
              out_ch.entry_count <= COUNT_W'(count);
              out_ch.valid       <= 1'b1;
              key_buf <= '0; pos <= '0; hsum <= '0;
            end else begin
              if (pos < PW'(KEY_CHARS)) begin
                key_buf[8*int'(pos) +: 8] <= {1'b0, in_ch.key_char};
                hsum <= hsum + HW'(in_ch.key_char) * HW'(pos + PW'(1));
                pos  <= pos + PW'(1);
              end else begin
                pos <= PW'(KEY_CHARS + 1);
              end
              if (in_ch.last_char) begin
                cmd_r <= in_ch.cmd;
                state <= S_HASH;
              end
            end
          end
        end
        S_HASH: begin
          hval  <= NB'(hprod);
          state <= S_QUOT;
        end
        S_QUOT: begin
          quot  <= NB'(qprod >> RS);
          state <= S_MOD;
        end
        S_MOD: begin
          hash      <= SW'(hrem);
          j         <= '0;
          step      <= (SW+1)'(24 % SLOTS);
          found     <= 1'b0;
          have_free <= 1'b0;
          state     <= S_READ;
          probe     <= SW'(hrem);
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (!found && rd_val && rd_key == key_buf) begin
            found <= 1'b1; hit_slot <= probe;
          end
          if (!have_free && !rd_val) begin
            have_free <= 1'b1; free_slot <= probe;
          end
          j     <= j + JW'(1);
          probe <= (probe_sum >= (SW+1)'(SLOTS)) ? SW'(probe_sum - (SW+1)'(SLOTS))
                                                  : SW'(probe_sum);
          step  <= (step_sum >= (SW+1)'(SLOTS)) ? step_sum - (SW+1)'(SLOTS) : step_sum;
          if (j == JW'(MAX_PROBES - 1) || (rd_val && rd_key == key_buf))
            state <= S_WRITE;
          else
            state <= S_READ;
        end
        S_WRITE: begin
          if (cmd_r == CMD_ADD) begin
            if (found) begin
              out_ch.status <= ST_PRESENT; out_ch.slot <= SLOT_W'(hit_slot);
            end else if (have_free) begin
              out_ch.status <= ST_INSERTED; out_ch.slot <= SLOT_W'(free_slot);
              count <= count + CW'(1);
            end else begin
              out_ch.status <= ST_FULL; out_ch.slot <= '0;
            end
          end else begin
            if (found) begin
              out_ch.status <= ST_DELETED; out_ch.slot <= SLOT_W'(hit_slot);
              count <= count - CW'(1);
            end else begin
              out_ch.status <= ST_MISSING; out_ch.slot <= '0;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_ch.entry_count <= COUNT_W'(count);
          out_ch.valid       <= 1'b1;
          key_buf <= '0; pos <= '0; hsum <= '0;
          state   <= S_COLLECT;
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  unused_hash_chk: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |=> (probe == hash))
    else $error("first probe not at hash");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("entry count beyond table size");

  a_noacc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_COLLECT) |-> !in_ch.ready)
    else $error("beat accepted while probing");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (probe < SW'(SLOTS)))
    else $error("probe slot out of range");

endmodule
